FILE: rtl/wpa_pkg.sv
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types and constants of the weighted pixel accumulation film.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int CSUM_W = 40;
  localparam int WSUM_W = 32;
  localparam int COMP_W = 16;
  localparam int OUT_W  = 18;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BLACK = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [OUT_W-1:0] OUT_CLAMP = 18'd256000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;
    logic [COMP_W-1:0] weight_in;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic [1:0]       read_status;
  } out_item_t;

endpackage

FILE: rtl/wpa_if.sv
// ----------------------------------------------------------------------------
// wpa_in_if / wpa_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wpa_in_if import wpa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wpa_out_if import wpa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/wpa_front.sv
// ----------------------------------------------------------------------------
// wpa_front
// Classifies items, checks range, computes the pixel index, and queues
// commands (two-entry queue) for the back end.
// ----------------------------------------------------------------------------
module wpa_front import wpa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int IDX_W      = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  input  logic [8:0]       width_i,
  input  logic [8:0]       height_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output logic [1:0]       cmd_kind_o,
  output logic             cmd_inside_o,
  output logic [IDX_W-1:0] cmd_idx_o,
  output logic [4*COMP_W-1:0] cmd_pay_o
);
  localparam int ENT_W = 3 + IDX_W + 4*COMP_W;
  // caps beyond 511 can never bind against a 9-bit size register
  localparam int MW = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
  localparam int MH = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

  logic [8:0]  wuse, huse;
  logic        in_range;
  logic [17:0] idx_full;
  logic [ENT_W-1:0] ent;
  logic [ENT_W-1:0] q_q [2];
  logic [ENT_W-1:0] q_d0, q_d1;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  // in range implies idx < wuse*huse <= MAX_WIDTH*MAX_HEIGHT
  always_comb begin
    wuse = (width_i  > 9'(MW)) ? 9'(MW) : width_i;
    huse = (height_i > 9'(MH)) ? 9'(MH) : height_i;
    idx_full = 18'(in_data_i.pixel_y) * 18'(wuse) + 18'(in_data_i.pixel_x);
    in_range = ({1'b0, in_data_i.pixel_x} < wuse) && ({1'b0, in_data_i.pixel_y} < huse);
    ent = {in_data_i.kind, in_range, IDX_W'(idx_full), in_data_i.red_in,
           in_data_i.green_in, in_data_i.blue_in, in_data_i.weight_in};
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && (in_data_i.kind != 2'd3);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign {cmd_kind_o, cmd_inside_o, cmd_idx_o, cmd_pay_o} = q_q[0];

  always_comb begin
    q_d0 = q_q[0];
    q_d1 = q_q[1];
    cnt_d = cnt_q;
    if (pop) begin
      q_d0 = q_q[1];
      cnt_d = cnt_d - 2'd1;
    end
    if (push) begin
      if (cnt_d == 2'd0) q_d0 = ent;
      else q_d1 = ent;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q[0] <= q_d0;
    q_q[1] <= q_d1;
  end
endmodule

FILE: rtl/wpa_div.sv
// ----------------------------------------------------------------------------
// wpa_div
// Iterative restoring divider: 40-bit by 32-bit, one quotient bit per cycle,
// three channels in parallel, clamped to 1000.0 in Q10.8.
// ----------------------------------------------------------------------------
module wpa_div import wpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CSUM_W-1:0] num_r_i,
  input  logic [CSUM_W-1:0] num_g_i,
  input  logic [CSUM_W-1:0] num_b_i,
  input  logic [WSUM_W-1:0] den_i,
  output logic              done_o,
  output logic [OUT_W-1:0]  q_r_o,
  output logic [OUT_W-1:0]  q_g_o,
  output logic [OUT_W-1:0]  q_b_o
);
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [WSUM_W-1:0] den_q;
  logic [CSUM_W-1:0] n_q [3];
  logic [WSUM_W:0]   r_q [3];
  logic [WSUM_W:0]   sh  [3];
  logic [WSUM_W:0]   df  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c] = {r_q[c][WSUM_W-1:0], n_q[c][CSUM_W-1]};
      df[c] = sh[c] - {1'b0, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(CSUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      n_q[0] <= num_r_i;
      n_q[1] <= num_g_i;
      n_q[2] <= num_b_i;
      for (int c = 0; c < 3; c++) r_q[c] <= '0;
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        if (!df[c][WSUM_W]) begin
          r_q[c] <= df[c];
          n_q[c] <= {n_q[c][CSUM_W-2:0], 1'b1};
        end else begin
          r_q[c] <= sh[c];
          n_q[c] <= {n_q[c][CSUM_W-2:0], 1'b0};
        end
      end
    end
  end

  function automatic logic [OUT_W-1:0] clamp(input logic [CSUM_W-1:0] v);
    return (v > CSUM_W'(OUT_CLAMP)) ? OUT_CLAMP : v[OUT_W-1:0];
  endfunction

  assign done_o = done_q;
  assign q_r_o = clamp(n_q[0]);
  assign q_g_o = clamp(n_q[1]);
  assign q_b_o = clamp(n_q[2]);
endmodule

FILE: rtl/wpa_back.sv
// ----------------------------------------------------------------------------
// wpa_back
// Pixel store with read-modify-write sequencer, clearing pass and resolve.
// ----------------------------------------------------------------------------
module wpa_back import wpa_pkg::*; #(
  parameter int IDX_W = 16,
  parameter int DEPTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [1:0]       cmd_kind_i,
  input  logic             cmd_inside_i,
  input  logic [IDX_W-1:0] cmd_idx_i,
  input  logic [4*COMP_W-1:0] cmd_pay_i,
  input  logic [15:0]      thresh_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam int MW = 3*CSUM_W + WSUM_W;

  logic [2:0]       st_q;
  logic [IDX_W:0]   clr_q;
  logic [MW-1:0]    mem [DEPTH];
  logic [MW-1:0]    rd_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       kind_q;
  logic [4*COMP_W-1:0] pay_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [MW-1:0]    wdata, nv;
  logic             ov_q;
  out_item_t        od_q;
  logic             div_start, div_done;
  logic [OUT_W-1:0] qr, qg, qb;

  logic [CSUM_W-1:0] sr, sg, sb;
  logic [WSUM_W-1:0] sw;
  logic [COMP_W-1:0] ri, gi, bi, wi;

  assign {sr, sg, sb, sw} = rd_q;
  assign {ri, gi, bi, wi} = pay_q;

  function automatic logic [CSUM_W-1:0] sat40(input logic [CSUM_W-1:0] a,
                                                input logic [COMP_W-1:0] c);
    logic [CSUM_W:0] s;
    s = {1'b0, a} + {17'd0, c, 8'd0};
    return s[CSUM_W] ? '1 : s[CSUM_W-1:0];
  endfunction

  always_comb begin
    logic [WSUM_W:0] ws;
    ws = {1'b0, sw} + {17'd0, wi};
    if (kind_q == KIND_ADD) begin
      nv = {sat40(sr, ri), sat40(sg, gi), sat40(sb, bi),
            ws[WSUM_W] ? {WSUM_W{1'b1}} : ws[WSUM_W-1:0]};
    end else begin
      nv = {8'd0, 32'(ri) * 32'(wi), 8'd0, 32'(gi) * 32'(wi),
            8'd0, 32'(bi) * 32'(wi), 16'd0, wi};
    end
  end

  assign we    = (st_q == S_CLR) || (st_q == S_WR);
  assign waddr = (st_q == S_CLR) ? clr_q[IDX_W-1:0] : idx_q;
  assign wdata = (st_q == S_CLR) ? '0 : nv;

  assign cmd_ready_o = (st_q == S_IDLE) && !ov_q;
  assign div_start   = (st_q == S_RD) && (kind_q == KIND_READ) &&
                       (sw != '0) && (sw >= WSUM_W'(thresh_i));

  wpa_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_r_i(sr), .num_g_i(sg), .num_b_i(sb), .den_i(sw),
    .done_o(div_done), .q_r_o(qr), .q_g_o(qg), .q_b_o(qb)
  );

  // pixel word is captured once per command and held until it retires
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_valid_i && cmd_ready_o) begin
      rd_q   <= mem[cmd_idx_i];
      idx_q  <= cmd_idx_i;
      kind_q <= cmd_kind_i;
      pay_q  <= cmd_pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      clr_q <= '0;
      ov_q  <= 1'b0;
      od_q  <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (IDX_W+1)'(DEPTH - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (!cmd_inside_i) begin
              if (cmd_kind_i == KIND_READ) begin
                ov_q <= 1'b1;
                od_q <= '{default: '0, read_status: ST_RANGE};
              end
            end else begin
              st_q <= S_RD;
            end
          end
        end
        S_RD: begin
          if (kind_q != KIND_READ) st_q <= S_WR;
          else if (div_start) st_q <= S_DIV;
          else begin
            ov_q <= 1'b1;
            od_q <= '{default: '0, read_status: ST_BLACK};
            st_q <= S_IDLE;
          end
        end
        S_WR: st_q <= S_IDLE;
        S_DIV: if (div_done) st_q <= S_OUT;
        S_OUT: begin
          ov_q <= 1'b1;
          od_q <= '{red_out: qr, green_out: qg, blue_out: qb, read_status: ST_OK};
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule

FILE: rtl/weighted_pixel_accumulation_film.sv
// ----------------------------------------------------------------------------
// weighted_pixel_accumulation_film
// Per-pixel weighted RGB accumulation store with resolve on read.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_if   | in  | valid/ready      | kind, pixel_x/y, rgb, weight (Q8.8)
//  out_if  | out | valid/ready      | rgb Q10.8, read_status
//  apb     | in  | psel/penable     | image_width, image_height, threshold
//
// Add/set pass through the back end as accept, read, write. A read of a pixel
// goes accept, read, then the 40-step divider, then the result; black
// and out-of-range reads answer without the divider. Front queue holds two.
// After reset a clearing pass zeroes the MAX_WIDTH*MAX_HEIGHT words of the store;
// items queue (two) but are not executed until it ends. A stalled result
// holds the back end; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module weighted_pixel_accumulation_film import wpa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpa_in_if.sink      in_if,
  wpa_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [15:0] thresh_q;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      thresh_q <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[8:0];
        REG_HEIGHT: height_q <= pwdata[8:0];
        REG_THRESH: thresh_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {23'd0, width_q};
      REG_HEIGHT: prdata = {23'd0, height_q};
      REG_THRESH: prdata = {16'd0, thresh_q};
      default:    prdata = '0;
    endcase
  end

  logic             cmd_valid, cmd_ready, cmd_inside;
  logic [1:0]       cmd_kind;
  logic [IDX_W-1:0] cmd_idx;
  logic [4*COMP_W-1:0] cmd_pay;

  wpa_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .IDX_W(IDX_W)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .width_i(width_q), .height_i(height_q),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_kind_o(cmd_kind),
    .cmd_inside_o(cmd_inside), .cmd_idx_o(cmd_idx), .cmd_pay_o(cmd_pay)
  );

  wpa_back #(.IDX_W(IDX_W), .DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_kind_i(cmd_kind),
    .cmd_inside_i(cmd_inside), .cmd_idx_i(cmd_idx), .cmd_pay_i(cmd_pay),
    .thresh_i(thresh_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

FILE: rtl/wpa_checker.sv
// ----------------------------------------------------------------------------
// wpa_checker
// Port-level checks of result items.
// ----------------------------------------------------------------------------
module wpa_checker import wpa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.red_out <= OUT_CLAMP && out_data_i.green_out <= OUT_CLAMP
                    && out_data_i.blue_out <= OUT_CLAMP)
    else $error("resolved color above clamp");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.read_status != ST_OK |->
      out_data_i.red_out == '0 && out_data_i.green_out == '0 && out_data_i.blue_out == '0)
    else $error("nonzero color on black or range status");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.read_status <= ST_RANGE)
    else $error("bad read status");
endmodule

bind weighted_pixel_accumulation_film wpa_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
